/* rtl/asmc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asmc_pkg: shared types and constants of the key modulus check block
// Holds the configuration register codes, character codes, reset values and
// the command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package asmc_pkg;

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 16;
  localparam int CHAR_W = 8;
  localparam int REM_W  = 16;

  typedef enum logic [CFG_AW-1:0] {
    CFG_MODULUS   = 2'd0,
    CFG_EXPECTED  = 2'd1,
    CFG_SEPARATOR = 2'd2
  } cfg_reg_t;

  localparam logic [15:0]       MODULUS_RST   = 16'd97;
  localparam logic [15:0]       EXPECTED_RST  = 16'd0;
  localparam logic [CHAR_W-1:0] SEPARATOR_RST = 8'h2D;

  localparam logic [CHAR_W-1:0] CHAR_0 = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_9 = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_Z = 8'h5A;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic k_zero;
    logic last;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

/* rtl/asmc_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asmc_in_if: input character channel
// Valid/ready channel carrying one key character and its end-of-key flag.
// ----------------------------------------------------------------------------
interface asmc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last_char;

  modport source (output valid, output character, output last_char, input ready);
  modport sink   (input valid, input character, input last_char, output ready);
endinterface
`default_nettype wire

/* rtl/asmc_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asmc_out_if: result channel
// Valid/ready channel carrying the final remainder and the match flag.
// ----------------------------------------------------------------------------
interface asmc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] remainder;
  logic        key_valid;

  modport source (output valid, output remainder, output key_valid, input ready);
  modport sink   (input valid, input remainder, input key_valid, output ready);
endinterface
`default_nettype wire

/* rtl/asmc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asmc_ctrl: sequencing controller
// Loads an item, runs the reduction steps and commits the new remainder.
// ----------------------------------------------------------------------------
module asmc_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire asmc_pkg::dp_status_t  status,
  output asmc_pkg::dp_cmd_t          cmd
);
  import asmc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.step = 1'b1;
        if (status.k_zero) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        // A final item must wait until the result register can take it.
        if (!status.last || status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/asmc_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asmc_dp: remainder datapath
// Holds the configuration, the running remainder, the shift-subtract
// reduction unit and the result register.
// ----------------------------------------------------------------------------
module asmc_dp #(
  parameter int MOD_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [asmc_pkg::CFG_AW-1:0]  cfg_addr,
  input  wire logic [asmc_pkg::CFG_DW-1:0]  cfg_wdata,
  input  wire logic [asmc_pkg::CHAR_W-1:0]  in_character,
  input  wire logic                         in_last_char,
  input  wire asmc_pkg::dp_cmd_t            cmd,
  output asmc_pkg::dp_status_t              status,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [asmc_pkg::REM_W-1:0]        out_remainder,
  output logic                              out_key_valid
);
  import asmc_pkg::*;

  // Widest value 100*r + 35 stays below 128 * 2^MOD_BITS.
  localparam int XW = MOD_BITS + 7;
  localparam int DW = MOD_BITS + XW;
  localparam int KW = $clog2(XW);
  localparam int CW = (MOD_BITS > REM_W) ? MOD_BITS : REM_W;

  localparam logic [KW-1:0] K_SEP    = KW'(0);
  localparam logic [KW-1:0] K_DIGIT  = KW'(3);
  localparam logic [KW-1:0] K_LETTER = KW'(6);
  localparam logic [KW-1:0] K_FULL   = KW'(XW - 1);

  logic [15:0]        modulus_r;
  logic [15:0]        expected_r;
  logic [CHAR_W-1:0]  separator_r;
  logic [MOD_BITS-1:0] run_r;
  logic [XW-1:0]      x_r;
  logic [DW-1:0]      d_r;
  logic [KW-1:0]      k_r;
  logic               last_r;
  logic               out_valid_r;
  logic [REM_W-1:0]   out_rem_r;
  logic               out_kv_r;

  logic [CW-1:0]       mod_ext;
  logic [MOD_BITS-1:0] n_raw;
  logic [MOD_BITS-1:0] n_eff;
  logic                is_sep;
  logic                is_digit;
  logic                is_letter;
  logic [6:0]          mult;
  logic [5:0]          add_v;
  logic [KW-1:0]       k_start;
  logic [XW-1:0]       x_load;
  logic                sub_ok;
  logic [CW-1:0]       res_word;
  logic                out_free;

  always_comb begin
    mod_ext = CW'(modulus_r);
    n_raw   = mod_ext[MOD_BITS-1:0];
    n_eff   = (n_raw < MOD_BITS'(2)) ? MOD_BITS'(2) : n_raw;

    is_sep    = (in_character == separator_r);
    is_digit  = (in_character >= CHAR_0) && (in_character <= CHAR_9);
    is_letter = (in_character >= CHAR_A) && (in_character <= CHAR_Z);

    // The separator only re-reduces; other non-alphanumerics append a zero.
    if (is_sep) begin
      mult    = 7'd1;
      add_v   = 6'd0;
      k_start = K_SEP;
    end else if (is_digit) begin
      mult    = 7'd10;
      add_v   = 6'(in_character - CHAR_0);
      k_start = K_DIGIT;
    end else if (is_letter) begin
      mult    = 7'd100;
      add_v   = 6'(in_character - CHAR_A) + 6'd10;
      k_start = K_LETTER;
    end else begin
      mult    = 7'd10;
      add_v   = 6'd0;
      k_start = K_DIGIT;
    end
    // A remainder left over from an older modulus needs the full-width pass.
    if (run_r >= n_eff) begin
      k_start = K_FULL;
    end
    x_load = (XW'(run_r) * XW'(mult)) + XW'(add_v);

    sub_ok   = (DW'(x_r) >= d_r);
    res_word = CW'(x_r[MOD_BITS-1:0]);
    out_free = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r   <= MODULUS_RST;
      expected_r  <= EXPECTED_RST;
      separator_r <= SEPARATOR_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        CFG_MODULUS:   modulus_r   <= cfg_wdata;
        CFG_EXPECTED:  expected_r  <= cfg_wdata;
        CFG_SEPARATOR: separator_r <= cfg_wdata[CHAR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit && last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.commit) begin
        if (last_r) begin
          run_r <= '0;
        end else begin
          run_r <= x_r[MOD_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r    <= x_load;
      d_r    <= DW'(n_eff) << k_start;
      k_r    <= k_start;
      last_r <= in_last_char;
    end else if (cmd.step) begin
      if (sub_ok) begin
        x_r <= x_r - d_r[XW-1:0];
      end
      d_r <= d_r >> 1;
      k_r <= k_r - KW'(1);
    end
    if (cmd.commit && last_r) begin
      out_rem_r <= res_word[REM_W-1:0];
      out_kv_r  <= (res_word == CW'(expected_r));
    end
  end

  assign status.k_zero   = (k_r == '0);
  assign status.last     = last_r;
  assign status.out_free = out_free;

  assign out_valid     = out_valid_r;
  assign out_remainder = out_rem_r;
  assign out_key_valid = out_kv_r;

endmodule
`default_nettype wire

/* rtl/alnum_string_modulus_check_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alnum_string_modulus_check_unit: alphanumeric key modulus check
// Accumulates the decimal number spelled by a key string modulo a configured
// modulus and reports the remainder and a match flag at the end of each key.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake        Payload
//  in_ch     sink       valid / ready    character[7:0], last_char
//  out_ch    source     valid / ready    remainder[15:0], key_valid
//  cfg_*     sink       cfg_we only      cfg_addr[1:0], cfg_wdata[15:0]
//
// An item is loaded, reduced in k shift-subtract steps of the reduction unit
// (7 for a letter, 4 for a digit or an unknown character and 1 for the
// separator) and then committed; no new item is accepted until then.
// When the modulus was lowered under a running remainder, the next item
// takes a reduction that covers the full width.
// Reset is synchronous: it restores the register defaults and clears the
// running remainder and the result valid flag. A final item whose result
// finds the result register still full waits there until it is taken;
// while it waits, the next item is not accepted.
//
// Every character maps the remainder r to (m * r + v) mod n, with m being
// 1, 10 or 100. The datapath forms m * r + v exactly and then reduces it
// by restoring subtraction of n shifted left by k, k counting down to zero.
// Since r < n normally holds, the starting shift is small: 100r + 35 < 128n.
// ----------------------------------------------------------------------------
module alnum_string_modulus_check_unit #(
  parameter int MOD_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [asmc_pkg::CFG_AW-1:0]  cfg_addr,
  input  wire logic [asmc_pkg::CFG_DW-1:0]  cfg_wdata,
  asmc_in_if.sink                           in_ch,
  asmc_out_if.source                        out_ch
);
  import asmc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // The controller only sequences; all values live in the datapath.
  asmc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  asmc_dp #(
    .MOD_BITS (MOD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_character  (in_ch.character),
    .in_last_char  (in_ch.last_char),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_remainder (out_ch.remainder),
    .out_key_valid (out_ch.key_valid)
  );

endmodule
`default_nettype wire

/* rtl/asmc_chk.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asmc_chk: port-level checker
// Watches the channels of the top level and flags ordering slips.
// ----------------------------------------------------------------------------
module asmc_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_remainder
);

  // A result stays offered, unchanged, until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_remainder))
    else $error("result dropped or changed while stalled");

  // An accepted item keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while the previous one was still in work");

  // A fresh result is only produced while an item is in work.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without an item in work");

  // Reset empties the result register.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind alnum_string_modulus_check_unit asmc_chk u_asmc_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_remainder (out_ch.remainder)
);
`default_nettype wire
